[rtl/bfa_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and sizing for the bitmap frame allocator.
// Used by every module of the block except bfa_ram; depends on nothing.
package bfa_pkg;

	// Map geometry
	localparam int MAP_BYTES   = 4096;
	localparam int PAGE_BYTES  = 4096;
	localparam int BYTE_BITS   = 8;
	localparam int WORD_BYTES  = 8;
	localparam int WORD_BITS   = WORD_BYTES * BYTE_BITS;
	localparam int BIT_W       = $clog2(WORD_BITS);
	localparam int FRAME_COUNT = MAP_BYTES * BYTE_BITS;
	localparam int MAP_WORDS   = (MAP_BYTES + WORD_BYTES - 1) / WORD_BYTES;
	localparam int ADDR_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);

	// Field widths
	localparam int OP_W    = 3;
	localparam int FRAME_W = 15;
	localparam int WIDX_W  = FRAME_W - BIT_W;
	localparam int FADDR_W = 27;
	localparam int IN_W    = 32;
	localparam int OUT_W   = 32;

	// Frames of the last word that lie inside the map
	localparam logic [WORD_BITS-1:0] TAIL_MASK =
		{WORD_BITS{1'b1}} >> (MAP_WORDS * WORD_BITS - FRAME_COUNT);

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC  = 3'd0,
		OP_FREE   = 3'd1,
		OP_QUERY  = 3'd2,
		OP_MARK   = 3'd3,
		OP_UNMARK = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} bfa_state_t;

	// Bit range to touch in one map word
	typedef struct packed {
		logic [BIT_W-1:0] lo_bit;
		logic [BIT_W-1:0] hi_bit;
		logic             tail_word;
		logic             set_bits;
	} wmod_t;

	// Word datapath results
	typedef struct packed {
		logic [WORD_BITS-1:0] mod_data;
		logic [WORD_BITS-1:0] alloc_data;
		logic                 zero_found;
		logic [BIT_W-1:0]     zero_pos;
	} wres_t;

endpackage

[rtl/bfa_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package needed.
module bfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[rtl/bfa_word.sv]
`timescale 1ns / 1ps
// Word datapath: range mask set/clear and lowest-free-frame search on one map word.
// Depends on bfa_pkg.
module bfa_word import bfa_pkg::*; (
	input  logic [WORD_BITS-1:0] rd_data,
	input  wmod_t                wmod,
	output wres_t                wres
);

	logic [WORD_BITS-1:0] lo_mask;
	logic [WORD_BITS-1:0] hi_mask;
	logic [WORD_BITS-1:0] mask;
	logic                 found;
	logic [BIT_W-1:0]     pos;

	// Build mask of bits lo_bit..hi_bit, clipped to the map on the tail word
	always_comb begin
		lo_mask = {WORD_BITS{1'b1}} << wmod.lo_bit;
		hi_mask = {WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - wmod.hi_bit);
		mask    = lo_mask & hi_mask;
		if (wmod.tail_word) begin
			mask = mask & TAIL_MASK;
		end
	end

	// Find the lowest clear bit; lowest byte first, then lowest bit in it
	always_comb begin
		found = 1'b0;
		pos   = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!rd_data[i]) begin
				found = 1'b1;
				pos   = BIT_W'(i);
			end
		end
	end

	always_comb begin
		wres.mod_data   = wmod.set_bits ? (rd_data | mask) : (rd_data & ~mask);
		wres.alloc_data = rd_data | ({{(WORD_BITS-1){1'b0}}, 1'b1} << pos);
		wres.zero_found = found;
		wres.zero_pos   = pos;
	end

endmodule

[rtl/bfa_seq.sv]
`timescale 1ns / 1ps
// Request sequencer: decodes requests, walks map words through the RAM with a
// read-modify-write pipeline, keeps the free-word hint and the result register.
// Depends on bfa_pkg.
module bfa_seq import bfa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// request stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_W-1:0]      s_tdata,
	input  logic [OP_W-1:0]      s_tuser,
	// result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata,
	// map RAM
	output logic                 wr_en,
	output logic [ADDR_W-1:0]    wr_addr,
	output logic [WORD_BITS-1:0] wr_data,
	output logic                 rd_en,
	output logic [ADDR_W-1:0]    rd_addr,
	input  logic [WORD_BITS-1:0] rd_data,
	// word datapath
	output wmod_t                wmod,
	input  wres_t                wres
);

	localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(MAP_WORDS - 1);
	localparam logic [ADDR_W:0]   WORDS_END = (ADDR_W + 1)'(MAP_WORDS);

	bfa_state_t state_q, state_d;

	op_t                op_q, op_d;
	logic [BIT_W-1:0]   first_bit_q, first_bit_d;
	logic [BIT_W-1:0]   last_bit_q, last_bit_d;
	logic [ADDR_W-1:0]  start_q, start_d;
	logic [ADDR_W-1:0]  end_q, end_d;
	logic               clip_q, clip_d;
	logic [ADDR_W:0]    cur_q, cur_d;
	logic [ADDR_W:0]    hint_q, hint_d;
	logic               v_s1;
	logic [ADDR_W-1:0]  addr_s1;

	logic               res_status_q, res_status_d;
	logic [FADDR_W-1:0] res_addr_q, res_addr_d;
	logic               res_isalloc_q, res_isalloc_d;
	logic               out_valid_q, out_valid_d;
	logic [OUT_W-1:0]   out_data_q;
	logic               out_load;

	logic               issue;
	logic               finish;

	// Request fields
	op_t                in_op;
	logic [FRAME_W-1:0] in_first;
	logic [FRAME_W-1:0] in_last;
	logic [WIDX_W-1:0]  in_first_word;
	logic [WIDX_W-1:0]  in_last_word;
	logic               first_in_map;
	logic               last_in_map;
	logic [ADDR_W:0]    first_word_ext;

	logic [ADDR_W+BIT_W-1:0]            alloc_frame;
	logic [ADDR_W+BIT_W+PAGE_SHIFT-1:0] alloc_bytes;

	assign in_op          = op_t'(s_tuser);
	assign in_first       = s_tdata[FRAME_W-1:0];
	assign in_last        = s_tdata[2*FRAME_W-1:FRAME_W];
	assign in_first_word  = in_first[FRAME_W-1:BIT_W];
	assign in_last_word   = in_last[FRAME_W-1:BIT_W];
	assign first_in_map   = 32'(in_first_word) < 32'(MAP_WORDS);
	assign last_in_map    = 32'(in_last_word) < 32'(MAP_WORDS);
	assign first_word_ext = (ADDR_W + 1)'(in_first_word);

	assign alloc_frame = {addr_s1, wres.zero_pos};
	assign alloc_bytes = {alloc_frame, {PAGE_SHIFT{1'b0}}};

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Word datapath controls for the word coming back from the RAM
	always_comb begin
		wmod.lo_bit    = (addr_s1 == start_q) ? first_bit_q : '0;
		wmod.hi_bit    = (addr_s1 == end_q && !clip_q) ? last_bit_q : BIT_W'(WORD_BITS - 1);
		wmod.tail_word = (addr_s1 == LAST_WORD);
		wmod.set_bits  = (op_q == OP_MARK);
	end

	// Next state, RAM access and result
	always_comb begin
		state_d       = state_q;
		op_d          = op_q;
		first_bit_d   = first_bit_q;
		last_bit_d    = last_bit_q;
		start_d       = start_q;
		end_d         = end_q;
		clip_d        = clip_q;
		cur_d         = cur_q;
		hint_d        = hint_q;
		res_status_d  = res_status_q;
		res_addr_d    = res_addr_q;
		res_isalloc_d = res_isalloc_q;
		out_valid_d   = out_valid_q && !m_tready;
		out_load      = 1'b0;
		wr_en         = 1'b0;
		wr_addr       = addr_s1;
		wr_data       = wres.mod_data;
		rd_en         = 1'b0;
		rd_addr       = cur_q[ADDR_W-1:0];
		issue         = 1'b0;
		finish        = 1'b0;

		unique case (state_q)
			ST_CLEAR: begin
				// Sweep the map to all allocated
				wr_en   = 1'b1;
				wr_addr = cur_q[ADDR_W-1:0];
				wr_data = {WORD_BITS{1'b1}};
				cur_d   = cur_q + 1'b1;
				if (cur_q[ADDR_W-1:0] == LAST_WORD) begin
					cur_d   = '0;
					state_d = ST_IDLE;
				end
			end

			ST_IDLE: begin
				if (s_tvalid) begin
					op_d          = in_op;
					first_bit_d   = in_first[BIT_W-1:0];
					last_bit_d    = in_last[BIT_W-1:0];
					start_d       = ADDR_W'(in_first_word);
					end_d         = ADDR_W'(in_first_word);
					clip_d        = 1'b0;
					cur_d         = (ADDR_W + 1)'(in_first_word);
					res_status_d  = 1'b0;
					res_addr_d    = '0;
					res_isalloc_d = 1'b0;
					state_d       = ST_DONE;
					unique case (in_op)
						OP_ALLOC: begin
							start_d = hint_q[ADDR_W-1:0];
							end_d   = LAST_WORD;
							cur_d   = hint_q;
							if (hint_q >= WORDS_END) begin
								res_status_d = 1'b1;
							end else begin
								state_d = ST_RUN;
							end
						end
						OP_FREE: begin
							last_bit_d = in_first[BIT_W-1:0];
							if (first_in_map) begin
								state_d = ST_RUN;
								if (first_word_ext < hint_q) begin
									hint_d = first_word_ext;
								end
							end
						end
						OP_QUERY: begin
							if (first_in_map) begin
								state_d = ST_RUN;
							end else begin
								res_isalloc_d = 1'b1;
							end
						end
						OP_MARK, OP_UNMARK: begin
							if (in_first <= in_last && first_in_map) begin
								state_d = ST_RUN;
								end_d   = last_in_map ? ADDR_W'(in_last_word) : LAST_WORD;
								clip_d  = !last_in_map;
								if (in_op == OP_UNMARK && first_word_ext < hint_q) begin
									hint_d = first_word_ext;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end

			ST_RUN: begin
				// Process the word read in the previous cycle
				if (v_s1) begin
					unique case (op_q)
						OP_ALLOC: begin
							if (wres.zero_found) begin
								wr_en      = 1'b1;
								wr_data    = wres.alloc_data;
								res_addr_d = FADDR_W'(alloc_bytes);
								hint_d     = (ADDR_W + 1)'(addr_s1);
								finish     = 1'b1;
							end else if (addr_s1 == LAST_WORD) begin
								res_status_d = 1'b1;
								hint_d       = WORDS_END;
								finish       = 1'b1;
							end
						end
						OP_QUERY: begin
							res_isalloc_d = rd_data[first_bit_q];
							finish        = 1'b1;
						end
						default: begin
							wr_en  = 1'b1;
							finish = (addr_s1 == end_q);
						end
					endcase
				end
				// Issue the next word read unless done
				issue = !finish && (cur_q <= {1'b0, end_q});
				rd_en = issue;
				if (issue) begin
					cur_d = cur_q + 1'b1;
				end
				if (finish) begin
					state_d = ST_DONE;
				end
			end

			ST_DONE: begin
				// Hand the result to the output register once it is free
				if (!out_valid_q || m_tready) begin
					out_load    = 1'b1;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cur_q       <= '0;
			hint_q      <= '0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cur_q       <= cur_d;
			hint_q      <= hint_d;
			v_s1        <= issue;
			out_valid_q <= out_valid_d;
		end
	end

	// Request, pipeline and result payload
	always_ff @(posedge clk) begin
		op_q          <= op_d;
		first_bit_q   <= first_bit_d;
		last_bit_q    <= last_bit_d;
		start_q       <= start_d;
		end_q         <= end_d;
		clip_q        <= clip_d;
		addr_s1       <= cur_q[ADDR_W-1:0];
		res_status_q  <= res_status_d;
		res_addr_q    <= res_addr_d;
		res_isalloc_q <= res_isalloc_d;
		if (out_load) begin
			out_data_q <= OUT_W'({res_isalloc_q, res_addr_q, res_status_q});
		end
	end

	// Returned read data only exists while a request walks the map
	a_s1_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> state_q == ST_RUN)
		else $error("read data returned outside a map walk");

	// Map writes only during the clearing sweep or a walk
	a_wr_state: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_CLEAR || state_q == ST_RUN))
		else $error("map write while idle or done");

	// Read and write never hit the same word in one cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("read and write of the same map word");

	// Hint stays within the map plus one
	a_hint_range: assert property (@(posedge clk) disable iff (!arst_n)
		hint_q <= WORDS_END)
		else $error("free-word hint out of range");

	// A new result only comes from the done state
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> state_q == ST_DONE)
		else $error("result loaded outside done state");

endmodule

[rtl/bitmap_frame_allocator_top.sv]
`timescale 1ns / 1ps
// Bitmap page frame allocator: one bit per frame held in a 64-bit-word RAM,
// with sequencer and word datapath. Depends on bfa_pkg, bfa_ram, bfa_word, bfa_seq.
//
// The map lives in one RAM of 512 words of 64 frames each; a set bit means
// the frame is allocated. After reset the block sweeps the RAM to all
// allocated and accepts no request until that is done. Each request then
// goes through the RAM's registered read with a read-modify-write of one map
// word per cycle: free and query touch a single word, a range mark walks
// each 64-frame word it covers, and an alloc scans words starting at a hint
// below which every word is known full. Requests with nothing to do (empty
// range, unused opcode, out of memory known from the hint) go straight to the
// done state without touching the map. One request is in work at a time;
// the result sits in an output register so the next request may enter while
// it waits to be taken.
module bitmap_frame_allocator_top import bfa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // first_frame[14:0], last_frame[29:15], zero pad
	input  logic [OP_W-1:0]  s_tuser,   // opcode[2:0]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata    // status[0], frame_address[27:1], is_allocated[28], zero pad
);

	logic                 wr_en;
	logic [ADDR_W-1:0]    wr_addr;
	logic [WORD_BITS-1:0] wr_data;
	logic                 rd_en;
	logic [ADDR_W-1:0]    rd_addr;
	logic [WORD_BITS-1:0] rd_data;
	wmod_t                wmod;
	wres_t                wres;

	// Frame map storage
	bfa_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (MAP_WORDS)
	) u_map (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Word modify and search
	bfa_word u_word (
		.rd_data (rd_data),
		.wmod    (wmod),
		.wres    (wres)
	);

	// Request sequencing
	bfa_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wmod     (wmod),
		.wres     (wres)
	);

endmodule
